[rtl/bali_pkg.sv]
// ----------------------------------------------------------------------------
// bali_pkg: shared types and constants for the bounded array list
// Opcodes, status codes and the per-cell shift control used by the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package bali_pkg;

	localparam int DATA_W      = 32;
	localparam int POS_W       = 5;
	localparam int IDX_W       = 4;
	localparam int MAX_RESULTS = 16;

	// input opcodes
	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_AT    = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_BACK  = 3'd4,
		OP_DEL_AT    = 3'd5,
		OP_READ      = 3'd6
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	// what one cell does on the next edge
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_LOAD  = 2'd1,
		CELL_LEFT  = 2'd2,
		CELL_RIGHT = 2'd3
	} cell_op_t;

endpackage

`default_nettype wire

[rtl/bali_cell.sv]
// ----------------------------------------------------------------------------
// bali_cell: one storage cell of the list row
// Holds one word; loads from the shared bus or takes a neighbor's word.
// ----------------------------------------------------------------------------
`default_nettype none

module bali_cell (
	input  wire                                clk,
	input  wire bali_pkg::cell_op_t            op,
	input  wire logic signed [bali_pkg::DATA_W-1:0] bus_data,
	input  wire logic signed [bali_pkg::DATA_W-1:0] left_data,
	input  wire logic signed [bali_pkg::DATA_W-1:0] right_data,
	output logic signed [bali_pkg::DATA_W-1:0]      data
);
	import bali_pkg::*;

	logic signed [DATA_W-1:0] data_q;

	// word register, no reset: contents undefined until written
	always_ff @(posedge clk) begin
		case (op)
			CELL_LOAD:  data_q <= bus_data;
			CELL_LEFT:  data_q <= left_data;
			CELL_RIGHT: data_q <= right_data;
			default:    data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

`default_nettype wire

[rtl/bounded_array_list_insert_delete.sv]
// ----------------------------------------------------------------------------
// bounded_array_list_insert_delete: ordered list with positional edits
// A row of DEPTH cells holds the list; edits shift the row at the edge that takes the command.
// ----------------------------------------------------------------------------
// Usage:
//   A command is transferred on a rising edge with start high and busy low.
//   opcode selects insert front/back/at, delete front/back/at or read out;
//   position and value are used as the opcode needs them.
//   Results appear on status, element, element_index and last for exactly
//   one cycle, marked by done; the receiver cannot stall, so every result
//   is transferred in the cycle it is shown.
//   Edits: one result, in the cycle after the command. busy stays low, so a
//   new command may follow in every cycle.
//   Read out: the row rotates one place per cycle through cell zero, which
//   feeds the results. busy stays high until the row has rotated back to
//   its start; each of the first min(count,16) steps yields one result,
//   the last one marked, through rd_active_q and the result register. An
//   empty list gives a single status empty result in the cycle after the
//   command. Opcode seven gives no result.
//   Reset empties the list and clears busy and done; cell contents are not
//   cleared, since only entries below count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_array_list_insert_delete #(
	parameter int DEPTH = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire logic [2:0]                     opcode,
	input  wire logic [bali_pkg::POS_W-1:0]     position,
	input  wire logic signed [bali_pkg::DATA_W-1:0] value,
	output logic                                done,
	output logic [1:0]                          status,
	output logic signed [bali_pkg::DATA_W-1:0]  element,
	output logic [bali_pkg::IDX_W-1:0]          element_index,
	output logic                                last
);
	import bali_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0]            count_q;
	logic                     rd_active_q;
	logic                     rd_emit_q;
	logic [CW-1:0]            rd_rot_q;
	logic [IDX_W-1:0]         rd_idx_q;
	logic [IDX_W-1:0]         rd_last_q;
	logic                     done_q;
	status_t                  status_q;
	logic signed [DATA_W-1:0] element_q;
	logic [IDX_W-1:0]         index_q;
	logic                     last_q;

	logic                     accept;
	logic                     is_ins;
	logic                     is_del;
	logic                     is_read;
	logic [PW-1:0]            epos;
	logic [PW-1:0]            cnt_x;
	logic [PW-1:0]            cnt_m1_x;
	status_t                  ed_status;
	logic                     edit_go;
	logic                     rd_fin;
	logic signed [DATA_W-1:0] bus_data;

	logic signed [DATA_W-1:0] cell_data [DEPTH];

	assign accept   = start && !busy;
	assign busy     = rd_active_q;
	assign cnt_x    = PW'(count_q);
	assign cnt_m1_x = PW'(count_q - CW'(1));
	assign rd_fin   = rd_emit_q && (rd_idx_q == rd_last_q);

	// command decode and edit status
	always_comb begin
		is_ins    = 1'b0;
		is_del    = 1'b0;
		is_read   = 1'b0;
		epos      = '0;
		ed_status = ST_OK;
		case (op_t'(opcode))
			OP_INS_FRONT: begin
				is_ins = 1'b1;
			end
			OP_INS_BACK: begin
				is_ins = 1'b1;
				epos   = cnt_x;
			end
			OP_INS_AT: begin
				is_ins = 1'b1;
				epos   = PW'(position);
			end
			OP_DEL_FRONT: begin
				is_del = 1'b1;
			end
			OP_DEL_BACK: begin
				is_del = 1'b1;
				epos   = cnt_m1_x;
			end
			OP_DEL_AT: begin
				is_del = 1'b1;
				epos   = PW'(position);
			end
			OP_READ: begin
				is_read = 1'b1;
			end
			default: begin
				is_ins = 1'b0;
			end
		endcase
		if (is_ins) begin
			if (epos > cnt_x) ed_status = ST_BADPOS;
			else if (count_q == CW'(DEPTH)) ed_status = ST_FULL;
		end else if (is_del) begin
			if (count_q == '0) ed_status = ST_EMPTY;
			else if (epos >= cnt_x) ed_status = ST_BADPOS;
		end
	end

	assign edit_go  = accept && (is_ins || is_del) && (ed_status == ST_OK);
	assign bus_data = rd_active_q ? cell_data[0] : value;

	// row of cells, each with its own shift control
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_d;
		logic signed [DATA_W-1:0] right_d;
		cell_op_t                 cop;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		// shift control for this cell
		always_comb begin
			cop = CELL_HOLD;
			if (rd_active_q) begin
				if (PW'(i) < cnt_m1_x) cop = CELL_RIGHT;
				else if (PW'(i) == cnt_m1_x) cop = CELL_LOAD;
			end else if (edit_go && is_ins) begin
				if (PW'(i) > epos) cop = CELL_LEFT;
				else if (PW'(i) == epos) cop = CELL_LOAD;
			end else if (edit_go && is_del) begin
				if (PW'(i) >= epos) cop = CELL_RIGHT;
			end
		end

		bali_cell u_cell (
			.clk        (clk),
			.op         (cop),
			.bus_data   (bus_data),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i])
		);
	end

	// count and read-out sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_active_q <= 1'b0;
			rd_emit_q   <= 1'b0;
			rd_rot_q    <= '0;
			rd_idx_q    <= '0;
			rd_last_q   <= '0;
		end else if (rd_active_q) begin
			rd_rot_q <= rd_rot_q - CW'(1);
			rd_idx_q <= rd_idx_q + IDX_W'(1);
			if (rd_fin) rd_emit_q <= 1'b0;
			if (rd_rot_q == CW'(1)) rd_active_q <= 1'b0;
		end else if (edit_go) begin
			if (is_ins) count_q <= count_q + CW'(1);
			else count_q <= count_q - CW'(1);
		end else if (accept && is_read && (count_q != '0)) begin
			rd_active_q <= 1'b1;
			rd_emit_q   <= 1'b1;
			rd_rot_q    <= count_q;
			rd_idx_q    <= '0;
			if (cnt_x >= PW'(MAX_RESULTS)) rd_last_q <= IDX_W'(MAX_RESULTS - 1);
			else rd_last_q <= IDX_W'(count_q - CW'(1));
		end
	end

	// result register: one transfer per cycle, never held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			status_q  <= ST_OK;
			element_q <= '0;
			index_q   <= '0;
			last_q    <= 1'b0;
		end else if (rd_active_q) begin
			done_q    <= rd_emit_q;
			status_q  <= ST_OK;
			element_q <= cell_data[0];
			index_q   <= rd_idx_q;
			last_q    <= rd_fin;
		end else if (accept && (is_ins || is_del)) begin
			done_q    <= 1'b1;
			status_q  <= ed_status;
			element_q <= '0;
			index_q   <= '0;
			last_q    <= 1'b1;
		end else if (accept && is_read && (count_q == '0)) begin
			done_q    <= 1'b1;
			status_q  <= ST_EMPTY;
			element_q <= '0;
			index_q   <= '0;
			last_q    <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign element       = element_q;
	assign element_index = index_q;
	assign last          = last_q;

	// count stays within the row
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("list count above depth");

	// every edit gives exactly one final result in the next cycle
	a_edit_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (is_ins || is_del) |=> done && last)
		else $error("edit without a final result");

	// an error status is always the only result of its command
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> last)
		else $error("error status on a non-final result");

	// read-out results come back to back until the marked one
	a_read_stream: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done)
		else $error("gap in read-out stream");

endmodule

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bounded_array_list_insert_delete
// Commands are driven from a queue; a shadow copy of the list predicts every
// status and read out result, and each strobed result is compared in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	import bali_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int IDLE_LIMIT = 1000;
	localparam int MAX_REPORTS = 10;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	typedef struct {
		logic [2:0]          op;
		logic [POS_W-1:0]    pos;
		logic signed [DATA_W-1:0] val;
		int                  gap;
		bit                  drain;
	} cmd_t;

	typedef struct {
		status_t             st;
		logic signed [DATA_W-1:0] elem;
		logic [IDX_W-1:0]    idx;
		logic                last;
	} result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [2:0]               opcode;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;
	logic                     done;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] element;
	logic [IDX_W-1:0]         element_index;
	logic                     last;

	cmd_t    cmd_queue[$];
	result_t pending_results[$];

	// shadow list used to predict results
	logic signed [DATA_W-1:0] list_cells [0:LIST_DEPTH-1];
	int                       list_count;

	// element count as seen by the command generator
	int gen_count;
	bit burst_mode;

	bit cmd_taken;
	int gap_cnt;
	int mismatches;
	int idle_cycles;

	bounded_array_list_insert_delete #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.position      (position),
		.value         (value),
		.done          (done),
		.status        (status),
		.element       (element),
		.element_index (element_index),
		.last          (last)
	);

	// clock and reset
	initial begin
		clk    = 1'b0;
		arst_n = 1'b0;
		start  = 1'b0;
		opcode = '0;
		position = '0;
		value  = '0;
		cmd_taken = 1'b0;
		gap_cnt = 0;
		mismatches = 0;
		idle_cycles = 0;
		list_count = 0;
		fork
			forever #4 clk = ~clk;
			begin
				repeat (3) @(posedge clk);
				@(negedge clk);
				arst_n = 1'b1;
			end
		join_none
	end

	// queue one command and track the element count it leaves behind
	task automatic push_cmd(input logic [2:0] op, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val, input bit drain);
		cmd_t c;
		int   at;
		c.op    = op;
		c.pos   = pos;
		c.val   = val;
		c.gap   = burst_mode ? 0 : $urandom_range(0, 8);
		c.drain = drain;
		cmd_queue.push_back(c);
		case (op)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
				at = (op == OP_INS_FRONT) ? 0 : (op == OP_INS_BACK) ? gen_count : int'(pos);
				if (at <= gen_count && gen_count < LIST_DEPTH)
					gen_count++;
			end
			OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
				at = (op == OP_DEL_FRONT) ? 0 : (op == OP_DEL_BACK) ? gen_count - 1 : int'(pos);
				if (gen_count > 0 && at < gen_count)
					gen_count--;
			end
			default: ;
		endcase
	endtask

	// apply one accepted command to the shadow list and queue its results
	task automatic apply_list_cmd(input logic [2:0] op, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		int      at;
		int      n;
		status_t st;
		result_t r;
		case (op)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
				at = (op == OP_INS_FRONT) ? 0 : (op == OP_INS_BACK) ? list_count : int'(pos);
				if (at > list_count)
					st = ST_BADPOS;
				else if (list_count >= LIST_DEPTH)
					st = ST_FULL;
				else begin
					for (int i = list_count; i > at; i--)
						list_cells[i] = list_cells[i-1];
					list_cells[at] = val;
					list_count++;
					st = ST_OK;
				end
				r = '{st, '0, '0, 1'b1};
				pending_results.push_back(r);
			end
			OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
				at = (op == OP_DEL_FRONT) ? 0 : (op == OP_DEL_BACK) ? list_count - 1 : int'(pos);
				// empty wins over a bad position
				if (list_count == 0)
					st = ST_EMPTY;
				else if (at >= list_count)
					st = ST_BADPOS;
				else begin
					for (int i = at; i + 1 < list_count; i++)
						list_cells[i] = list_cells[i+1];
					list_count--;
					st = ST_OK;
				end
				r = '{st, '0, '0, 1'b1};
				pending_results.push_back(r);
			end
			OP_READ: begin
				n = (list_count < MAX_RESULTS) ? list_count : MAX_RESULTS;
				if (n == 0) begin
					r = '{ST_EMPTY, '0, '0, 1'b1};
					pending_results.push_back(r);
				end else begin
					for (int i = 0; i < n; i++) begin
						r = '{ST_OK, list_cells[i], IDX_W'(i), (i == n - 1)};
						pending_results.push_back(r);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic note_failure(input string msg);
		if (mismatches < MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// command driver: one transfer per item, random gaps before each outside burst mode
	always @(negedge clk) begin
		if (arst_n) begin
			if (!start || cmd_taken) begin
				cmd_taken = 1'b0;
				if (cmd_queue.size() == 0 ||
						(cmd_queue[0].drain && pending_results.size() != 0) ||
						gap_cnt < cmd_queue[0].gap) begin
					start    <= 1'b0;
					opcode   <= 3'($urandom);
					position <= POS_W'($urandom);
					value    <= $urandom;
					if (cmd_queue.size() != 0)
						gap_cnt++;
				end else begin
					start    <= 1'b1;
					opcode   <= cmd_queue[0].op;
					position <= cmd_queue[0].pos;
					value    <= cmd_queue[0].val;
					gap_cnt  = 0;
					void'(cmd_queue.pop_front());
				end
			end
		end
	end

	// result monitor, prediction on each command transfer, and watchdog
	always @(posedge clk) begin
		result_t exp_r;
		if (done) begin
			if (pending_results.size() == 0)
				note_failure($sformatf("unexpected result status=%0d element=%0d index=%0d last=%0b",
					status, element, element_index, last));
			else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.st || element !== exp_r.elem ||
						element_index !== exp_r.idx || last !== exp_r.last)
					note_failure($sformatf({"result mismatch: expected status=%0d element=%0d ",
						"index=%0d last=%0b, got status=%0d element=%0d index=%0d last=%0b"},
						exp_r.st, exp_r.elem, exp_r.idx, exp_r.last,
						status, element, element_index, last));
			end
		end
		if (arst_n && start && !busy) begin
			apply_list_cmd(opcode, position, value);
			cmd_taken = 1'b1;
		end
		if (done || (start && !busy))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("[bounded_array_list_insert_delete] ERROR");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		op_t ins_ops [3];
		op_t del_ops [3];
		int  items;
		int  mode;
		int  len;
		int  r;
		logic [2:0] op;
		logic [POS_W-1:0] pos;
		logic signed [DATA_W-1:0] val;

		ins_ops = '{OP_INS_FRONT, OP_INS_BACK, OP_INS_AT};
		del_ops = '{OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT};
		gen_count = 0;
		burst_mode = 1'b0;

		// directed: empty list cases
		push_cmd(OP_READ, 0, 0, 1'b0);
		push_cmd(OP_DEL_FRONT, 0, 0, 1'b0);
		push_cmd(OP_DEL_BACK, 0, 0, 1'b0);
		push_cmd(OP_DEL_AT, 5, 0, 1'b0);
		push_cmd(OP_INS_AT, 1, 32'sd5, 1'b0);
		push_cmd(OP_UNUSED, 31, -1, 1'b0);
		// directed: extremes, insert at count, delete at count
		push_cmd(OP_INS_FRONT, 0, 32'sh7fffffff, 1'b0);
		push_cmd(OP_INS_BACK, 31, 32'sh80000000, 1'b0);
		push_cmd(OP_INS_AT, 1, -1, 1'b0);
		push_cmd(OP_INS_AT, 3, 0, 1'b0);
		push_cmd(OP_DEL_AT, 4, -1, 1'b0);
		push_cmd(OP_DEL_AT, 1, 0, 1'b0);
		push_cmd(OP_READ, 0, 0, 1'b0);
		// directed: fill up, then full and bad position over full
		burst_mode = 1'b1;
		while (gen_count < LIST_DEPTH)
			push_cmd(OP_INS_AT, POS_W'($urandom_range(0, gen_count)), $urandom, 1'b0);
		burst_mode = 1'b0;
		push_cmd(OP_INS_FRONT, 0, 1, 1'b0);
		push_cmd(OP_INS_AT, 31, 2, 1'b0);
		push_cmd(OP_READ, 0, 0, 1'b1);
		push_cmd(OP_DEL_AT, 16, 0, 1'b0);
		push_cmd(OP_DEL_BACK, 0, 0, 1'b0);

		// random episodes biased toward filling, draining or mixed edits
		items = cmd_queue.size();
		while (items < 170) begin
			mode = $urandom_range(0, 2);
			len = $urandom_range(6, 20);
			burst_mode = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < len; k++) begin
				r = $urandom_range(0, 99);
				if (r < ((mode == 0) ? 65 : (mode == 1) ? 25 : 45))
					op = ins_ops[$urandom_range(0, 2)];
				else if (r < ((mode == 0) ? 85 : (mode == 1) ? 80 : 85))
					op = del_ops[$urandom_range(0, 2)];
				else if (r < 97)
					op = OP_READ;
				else
					op = OP_UNUSED;
				r = $urandom_range(0, 19);
				if (r < 15)
					pos = POS_W'($urandom_range(0, gen_count));
				else if (r < 19)
					pos = POS_W'($urandom_range(0, 16));
				else
					pos = POS_W'($urandom_range(17, 31));
				case ($urandom_range(0, 11))
					0: val = 32'sh7fffffff;
					1: val = 32'sh80000000;
					2: val = 0;
					3: val = -1;
					default: val = $urandom;
				endcase
				push_cmd(op, pos, val, (k == 0) && ($urandom_range(0, 2) == 0));
				if (op != OP_UNUSED)
					items++;
			end
		end

		wait (arst_n);
		while (cmd_queue.size() != 0 || start)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[bounded_array_list_insert_delete] OK");
		else
			$display("[bounded_array_list_insert_delete] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
